// ===== rtl/kcs_pkg.sv =====
// Package for the keyframe channel sampler: sizes, op codes and item types.
// Used by every module of the block; depends on nothing.
package kcs_pkg;

	localparam int MAX_KEYS    = 64;
	localparam int KEY_AW      = 6;
	localparam int MAX_LANES   = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QAW         = 1;

	localparam logic [16:0] FRAC_ONE   = 17'd65536;
	localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000;
	localparam logic [4:0]  FRAC_STEPS = 5'd16;
	localparam logic [4:0]  NORM_STEPS = 5'd17;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_EMPTY  = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic REG_KEY_COUNT  = 1'b0;
	localparam logic REG_LANE_COUNT = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [5:0]         key_index;
		logic signed [31:0] key_time;
		logic signed [31:0] value_0;
		logic signed [31:0] value_1;
		logic signed [31:0] value_2;
		logic signed [31:0] value_3;
		logic signed [31:0] query_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] lane_out_0;
		logic signed [31:0] lane_out_1;
		logic signed [31:0] lane_out_2;
		logic signed [31:0] lane_out_3;
		logic [5:0]         base_key;
		logic [16:0]        fraction;
	} result_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [KEY_AW-1:0]  key_index;
		logic signed [31:0] key_time;
		logic [127:0]       vals;
		logic signed [31:0] query_time;
		logic [6:0]         n;
		logic [2:0]         lanes;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [4:0]  steps;
		logic [31:0] rem0;
		logic [16:0] low0;
		logic [31:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/kcs_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on kcs_pkg.
module kcs_front import kcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	input  logic [6:0] key_count,
	input  logic [2:0] lane_count,
	output logic      busy,
	input  logic      pop,
	output logic      cmd_valid,
	output cmd_t      cmd
);

	cmd_t           q_mem [QUEUE_DEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	cmd_t           cls;
	logic           push;

	assign busy      = cnt_q == (QAW+1)'(QUEUE_DEPTH);
	assign push      = start && !busy;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_mem[rp_q];

	always_comb begin
		cls.key_index  = item.key_index;
		cls.key_time   = item.key_time;
		cls.vals       = {item.value_3, item.value_2, item.value_1, item.value_0};
		cls.query_time = item.query_time;
		cls.n          = (key_count > 7'(MAX_KEYS)) ? 7'(MAX_KEYS) : key_count;
		if (lane_count == 3'd0) begin
			cls.lanes = 3'd1;
		end else if (lane_count > 3'(MAX_LANES)) begin
			cls.lanes = 3'(MAX_LANES);
		end else begin
			cls.lanes = lane_count;
		end
		if (item.kind == KIND_LOAD) begin
			cls.op = OP_LOAD;
		end else if (cls.n == 7'd0) begin
			cls.op = OP_EMPTY;
		end else begin
			cls.op = OP_SAMPLE;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule

// ===== rtl/kcs_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by fraction and norm.
// Depends on kcs_pkg.
module kcs_div import kcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [16:0] quot
);

	logic [31:0] rem_q, dvs_q;
	logic [16:0] low_q, quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] remx, diff;
	logic        ge;

	assign remx = {rem_q, low_q[16]};
	assign ge   = remx >= {1'b0, dvs_q};
	assign diff = remx - {1'b0, dvs_q};
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem0;
			low_q  <= req.low0;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[31:0] : remx[31:0];
			low_q  <= {low_q[15:0], 1'b0};
			quot_q <= {quot_q[15:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/kcs_back.sv =====
// Back end: key stores, binary search, fraction, lane blend and quaternion
// normalisation as one sequencer. Depends on kcs_pkg and kcs_div.
module kcs_back import kcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    pop,
	output logic    done,
	output result_t result
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_S_RD  = 5'd1;
	localparam logic [4:0] ST_S_CMP = 5'd2;
	localparam logic [4:0] ST_RD0   = 5'd3;
	localparam logic [4:0] ST_RD1   = 5'd4;
	localparam logic [4:0] ST_CAP1  = 5'd5;
	localparam logic [4:0] ST_FRAC  = 5'd6;
	localparam logic [4:0] ST_FDIV  = 5'd7;
	localparam logic [4:0] ST_DOT_M = 5'd8;
	localparam logic [4:0] ST_DOT_A = 5'd9;
	localparam logic [4:0] ST_I_M   = 5'd10;
	localparam logic [4:0] ST_I_A   = 5'd11;
	localparam logic [4:0] ST_Q_M   = 5'd12;
	localparam logic [4:0] ST_Q_A   = 5'd13;
	localparam logic [4:0] ST_SQRT  = 5'd14;
	localparam logic [4:0] ST_N_ST  = 5'd15;
	localparam logic [4:0] ST_N_W   = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	logic signed [31:0] tmem [MAX_KEYS];
	logic [127:0]       vmem [MAX_KEYS];
	logic signed [31:0] tdat_q;
	logic [127:0]       vdat_q;
	logic [KEY_AW-1:0]  raddr;

	logic [4:0]         state_q;
	logic signed [31:0] q_q, t0_q, t1_q;
	logic [6:0]         n_q, lo_q, cnt_q;
	logic [2:0]         lanes_q;
	logic [KEY_AW-1:0]  base_q, nxt_q;
	logic               has_next_q;
	logic [127:0]       from_q, to_q;
	logic [16:0]        frac_q;
	logic [1:0]         li_q;
	logic signed [65:0] acc_q;
	logic signed [32:0] res_q [MAX_LANES];
	logic [63:0]        sq_q, x_q, r_q, bit_q;
	logic [4:0]         sqc_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	logic [6:0]         step, at7;
	logic signed [31:0] from_l, to_l;
	logic signed [33:0] t34, diff34, blend;
	logic signed [32:0] span, num, cur, mag33;
	logic               quat;
	logic [64:0]        sq_sum;
	logic [63:0]        sq_next, sr_try;
	div_req_t           div_req;
	logic               div_done;
	logic [16:0]        div_quot;

	assign pop  = (state_q == ST_IDLE) && cmd_valid;
	assign done = state_q == ST_OUT;
	assign quat = lanes_q == 3'(MAX_LANES);

	assign step   = {1'b0, cnt_q[6:1]};
	assign at7    = lo_q + step;
	assign from_l = from_q[li_q*32 +: 32];
	assign to_l   = to_q[li_q*32 +: 32];
	assign t34    = acc_q[65] ? -34'(to_l) : 34'(to_l);
	assign diff34 = t34 - 34'(from_l);
	assign blend  = 34'(from_l) + prod_q[49:16];
	assign span   = 33'(t1_q) - 33'(t0_q);
	assign num    = 33'(q_q) - 33'(t0_q);
	assign cur    = res_q[li_q];
	assign mag33  = cur[32] ? -cur : cur;
	assign sq_sum = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
	assign sq_next = sq_sum[64] ? '1 : sq_sum[63:0];
	assign sr_try = r_q + bit_q;

	always_comb begin
		case (state_q)
			ST_S_RD: raddr = at7[KEY_AW-1:0];
			ST_RD0:  raddr = base_q;
			ST_RD1:  raddr = nxt_q;
			default: raddr = base_q;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_DOT_M: begin
				mul_a = 34'(from_l);
				mul_b = 34'(to_l);
			end
			ST_I_M: begin
				mul_a = diff34;
				mul_b = {17'd0, frac_q};
			end
			ST_Q_M: begin
				mul_a = {1'b0, mag33};
				mul_b = {1'b0, mag33};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.start   = 1'b0;
		div_req.steps   = FRAC_STEPS;
		div_req.rem0    = num[31:0];
		div_req.low0    = '0;
		div_req.divisor = span[31:0];
		if (state_q == ST_FRAC) begin
			div_req.start = has_next_q && !span[32] && span != '0 && !num[32] &&
				num != '0 && num < span;
		end else if (state_q == ST_N_ST) begin
			div_req.start   = r_q != '0;
			div_req.steps   = NORM_STEPS;
			div_req.rem0    = {1'b0, mag33[31:1]};
			div_req.low0    = {mag33[0], 16'd0};
			div_req.divisor = r_q[31:0];
		end
	end

	kcs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_LOAD) begin
			tmem[cmd.key_index] <= cmd.key_time;
			vmem[cmd.key_index] <= cmd.vals;
		end
		tdat_q <= tmem[raddr];
		vdat_q <= vmem[raddr];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						q_q     <= cmd.query_time;
						n_q     <= cmd.n;
						lanes_q <= cmd.lanes;
						lo_q    <= '0;
						cnt_q   <= cmd.n;
						base_q  <= '0;
						frac_q  <= '0;
						acc_q   <= '0;
						sq_q    <= '0;
						li_q    <= '0;
						for (int i = 0; i < MAX_LANES; i++) begin
							res_q[i] <= '0;
						end
						if (cmd.op == OP_EMPTY) begin
							state_q <= ST_OUT;
						end else if (cmd.op == OP_SAMPLE) begin
							state_q <= (cmd.n >= 7'd2) ? ST_S_RD : ST_RD0;
						end
					end
				end
				ST_S_RD: begin
					if (cnt_q == '0) begin
						base_q  <= (lo_q == '0) ? '0 : KEY_AW'(lo_q - 7'd1);
						state_q <= ST_RD0;
					end else begin
						state_q <= ST_S_CMP;
					end
				end
				ST_S_CMP: begin
					if (!(q_q < tdat_q)) begin
						lo_q  <= at7 + 7'd1;
						cnt_q <= cnt_q - step - 7'd1;
					end else begin
						cnt_q <= step;
					end
					state_q <= ST_S_RD;
				end
				ST_RD0: begin
					has_next_q <= ({1'b0, base_q} + 7'd1) < n_q;
					nxt_q      <= (({1'b0, base_q} + 7'd1) < n_q) ? base_q + 1'b1 : base_q;
					state_q    <= ST_RD1;
				end
				ST_RD1: begin
					t0_q    <= tdat_q;
					from_q  <= vdat_q;
					state_q <= ST_CAP1;
				end
				ST_CAP1: begin
					t1_q    <= tdat_q;
					to_q    <= vdat_q;
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					if (div_req.start) begin
						state_q <= ST_FDIV;
					end else begin
						if (has_next_q && !span[32] && span != '0 && !num[32] &&
							num != '0) begin
							frac_q <= FRAC_ONE;
						end
						state_q <= quat ? ST_DOT_M : ST_I_M;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						frac_q  <= div_quot;
						state_q <= quat ? ST_DOT_M : ST_I_M;
					end
				end
				ST_DOT_M: begin
					state_q <= ST_DOT_A;
				end
				ST_DOT_A: begin
					acc_q <= acc_q + prod_q[65:0];
					li_q  <= li_q + 2'd1;
					state_q <= (li_q == 2'd3) ? ST_I_M : ST_DOT_M;
				end
				ST_I_M: begin
					state_q <= ST_I_A;
				end
				ST_I_A: begin
					if ({1'b0, li_q} < lanes_q) begin
						res_q[li_q] <= blend[32:0];
					end
					if (quat) begin
						state_q <= ST_Q_M;
					end else begin
						li_q    <= li_q + 2'd1;
						state_q <= (li_q == 2'd3) ? ST_OUT : ST_I_M;
					end
				end
				ST_Q_M: begin
					state_q <= ST_Q_A;
				end
				ST_Q_A: begin
					sq_q  <= sq_next;
					li_q  <= li_q + 2'd1;
					if (li_q == 2'd3) begin
						x_q     <= sq_next;
						r_q     <= '0;
						bit_q   <= SQRT_TOP;
						sqc_q   <= 5'd31;
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_I_M;
					end
				end
				ST_SQRT: begin
					if (x_q >= sr_try) begin
						x_q <= x_q - sr_try;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					sqc_q <= sqc_q - 5'd1;
					if (sqc_q == '0) begin
						state_q <= ST_N_ST;
					end
				end
				ST_N_ST: begin
					if (r_q == '0) begin
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						res_q[3] <= 33'sd65536;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_N_W;
					end
				end
				ST_N_W: begin
					if (div_done) begin
						res_q[li_q] <= cur[32] ? -{16'd0, div_quot} : {16'd0, div_quot};
						li_q        <= li_q + 2'd1;
						state_q     <= (li_q == 2'd3) ? ST_OUT : ST_N_ST;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.lane_out_0 = res_q[0][31:0];
	assign result.lane_out_1 = res_q[1][31:0];
	assign result.lane_out_2 = res_q[2][31:0];
	assign result.lane_out_3 = res_q[3][31:0];
	assign result.base_key   = base_q;
	assign result.fraction   = frac_q;

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.fraction <= FRAC_ONE)
		else $error("fraction above one");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_FDIV || state_q == ST_N_W))
		else $error("divider finished with no waiting state");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_N_ST && r_q == '0) |=>
		(state_q == ST_OUT && result.lane_out_3 == 32'sd65536))
		else $error("zero length did not give identity");

endmodule

// ===== rtl/keyframe_channel_sampler_unit.sv =====
// Top level of the keyframe channel sampler: config registers, front, back.
// Depends on kcs_pkg, kcs_front, kcs_back.
//
//  channel  | ports                             | handshake
//  ---------+-----------------------------------+--------------------------
//  item in  | start, busy, item                 | taken when start && !busy
//  result   | done, result                      | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data       | written when cfg_we
//
// A load item is written to the key stores when it is popped; a sample item is
// held up by the one-bit-a-cycle divider (fraction, and with four lanes four
// normalisations) and, with four lanes, by the 32-step square root.
// A two-item queue lets the front take items while the back end works.
// Reset clears control; config to 0 keys, 3 lanes; key stores unset till loaded.
module keyframe_channel_sampler_unit import kcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	logic [6:0] key_count_q;
	logic [2:0] lane_count_q;
	logic       pop, cmd_valid;
	cmd_t       cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= 7'd0;
			lane_count_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_COUNT:  key_count_q  <= cfg_data;
				REG_LANE_COUNT: lane_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	kcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.key_count (key_count_q),
		.lane_count(lane_count_q),
		.busy      (busy),
		.pop       (pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	kcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== tb/keyframe_channel_sampler_unit_test.sv =====
// Testbench for keyframe_channel_sampler_unit: loads keys, samples, checks each result
// against a cycle-free predictor of search, fraction, lerp and quaternion nlerp.
// Depends on kcs_pkg and the keyframe_channel_sampler_unit RTL.
`timescale 1ns / 100ps

module keyframe_channel_sampler_unit_test import kcs_pkg::*; ();

	localparam int   SETTLE_CYCLES  = 600;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	in_item_t   item;
	logic       done;
	result_t    result;
	logic       cfg_we;
	logic       cfg_index;
	logic [6:0] cfg_data;

	keyframe_channel_sampler_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	longint  key_times [MAX_KEYS];
	longint  key_lanes [MAX_KEYS][4];
	int      key_count_reg;
	int      lane_count_reg;
	result_t expected_samples [$];
	int      errors;
	bit      idling_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic result_t predict_sample(input logic signed [31:0] qt);
		result_t                r;
		longint                 q, span, num, f, tv, fv, mg;
		int                     n, lanes, lo, cnt, stp, at, base, nxt;
		longint                 res [4];
		logic signed [127:0]    dot;
		logic [127:0]           sq;
		logic [63:0]            len, mag;
		bit                     flip;
		r = '0;
		q = qt;
		n = key_count_reg > MAX_KEYS ? MAX_KEYS : key_count_reg;
		lanes = lane_count_reg == 0 ? 1 : (lane_count_reg > 4 ? 4 : lane_count_reg);
		if (n == 0) return r;
		base = 0;
		if (n >= 2) begin
			lo = 0;
			cnt = n;
			while (cnt > 0) begin
				stp = cnt / 2;
				at = lo + stp;
				if (!(q < key_times[at])) begin
					lo = at + 1;
					cnt = cnt - (stp + 1);
				end else begin
					cnt = stp;
				end
			end
			base = lo == 0 ? 0 : lo - 1;
		end
		nxt = base + 1 < n ? base + 1 : base;
		f = 0;
		if (base + 1 < n) begin
			span = key_times[base + 1] - key_times[base];
			num = q - key_times[base];
			if (span > 0)
				f = num <= 0 ? 0 : (num >= span ? 65536 : (num * 65536) / span);
		end
		for (int i = 0; i < 4; i++) res[i] = 0;
		if (lanes == 4) begin
			dot = '0;
			for (int i = 0; i < 4; i++)
				dot = dot + key_lanes[base][i] * key_lanes[nxt][i];
			flip = dot < 0;
			sq = '0;
			for (int i = 0; i < 4; i++) begin
				fv = key_lanes[base][i];
				tv = flip ? -key_lanes[nxt][i] : key_lanes[nxt][i];
				res[i] = fv + (((tv - fv) * f) >>> 16);
				mg = res[i] < 0 ? -res[i] : res[i];
				mag = mg;
				sq = sq + mag * mag;
			end
			if (sq > 128'hFFFF_FFFF_FFFF_FFFF) sq = 128'hFFFF_FFFF_FFFF_FFFF;
			len = isqrt64(sq[63:0]);
			if (len == 0) begin
				res[0] = 0; res[1] = 0; res[2] = 0; res[3] = 65536;
			end else begin
				for (int i = 0; i < 4; i++) begin
					mg = res[i] < 0 ? -res[i] : res[i];
					mag = mg;
					mg = longint'((mag << 16) / len);
					res[i] = res[i] < 0 ? -mg : mg;
				end
			end
		end else begin
			for (int i = 0; i < lanes; i++)
				res[i] = key_lanes[base][i]
					+ (((key_lanes[nxt][i] - key_lanes[base][i]) * f) >>> 16);
		end
		r.lane_out_0 = res[0][31:0];
		r.lane_out_1 = res[1][31:0];
		r.lane_out_2 = res[2][31:0];
		r.lane_out_3 = res[3][31:0];
		r.base_key   = base[5:0];
		r.fraction   = f[16:0];
		return r;
	endfunction

	function automatic void accept_item(input in_item_t it);
		if (it.kind == KIND_LOAD) begin
			key_times[it.key_index]    = it.key_time;
			key_lanes[it.key_index][0] = it.value_0;
			key_lanes[it.key_index][1] = it.value_1;
			key_lanes[it.key_index][2] = it.value_2;
			key_lanes[it.key_index][3] = it.value_3;
		end else begin
			expected_samples = {expected_samples, predict_sample(it.query_time)};
		end
	endfunction

	// result checker: strobe sampled at the edge that ends its cycle
	task automatic check_field(input string nm, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch expected %0h actual %0h", $time, nm, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result expected none actual %p", $time, result);
				errors++;
			end else begin
				e = expected_samples.pop_front();
				check_field("lane_out_0", e.lane_out_0, result.lane_out_0);
				check_field("lane_out_1", e.lane_out_1, result.lane_out_1);
				check_field("lane_out_2", e.lane_out_2, result.lane_out_2);
				check_field("lane_out_3", e.lane_out_3, result.lane_out_3);
				check_field("base_key", 32'(e.base_key), 32'(result.base_key));
				check_field("fraction", 32'(e.fraction), 32'(result.fraction));
			end
		end
	end

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		while (busy) @(negedge clk);
		@(posedge clk);
		accept_item(it);
	endtask

	task automatic maybe_pause();
		int n;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[6:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_COUNT) key_count_reg = val & 7'h7F;
		else lane_count_reg = val & 3'h7;
	endtask

	function automatic in_item_t load_item(input int idx, input logic [31:0] t,
			input logic [31:0] v0, v1, v2, v3);
		in_item_t     it;
		logic [223:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.kind = KIND_LOAD;
		it.key_index = idx[5:0];
		it.key_time = t;
		it.value_0 = v0; it.value_1 = v1; it.value_2 = v2; it.value_3 = v3;
		return it;
	endfunction

	function automatic in_item_t sample_item(input logic [31:0] q);
		in_item_t     it;
		logic [223:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.kind = KIND_SAMPLE;
		it.query_time = q;
		return it;
	endfunction

	task automatic test_empty_channel();
		send_item(sample_item(32'h8000_0000));
		send_item(sample_item(32'h7FFF_FFFF));
		send_item(sample_item(32'h0));
	endtask

	task automatic test_full_load();
		for (int i = 0; i < MAX_KEYS; i++) begin
			send_item(load_item(i, i * 65536 - 32 * 65536, $urandom, $urandom,
				(i == 3) ? 32'h8000_0000 : $urandom, (i == 4) ? 32'h7FFF_FFFF : $urandom));
			maybe_pause();
		end
	endtask

	task automatic test_interpolation();
		int kc [4] = '{1, 2, 64, 127};
		foreach (kc[k]) begin
			drain();
			write_reg(REG_KEY_COUNT, kc[k]);
			write_reg(REG_LANE_COUNT, k == 0 ? 0 : 7 - k);
			send_item(sample_item(32'h8000_0000));
			send_item(sample_item(-20 * 65536 + 32768));
			send_item(sample_item(31 * 65536));
			send_item(sample_item(32'h7FFF_FFFF));
		end
		drain();
		for (int l = 1; l <= 4; l++) begin
			write_reg(REG_LANE_COUNT, l);
			send_item(sample_item(-5 * 65536 + 12345));
			drain();
		end
	endtask

	task automatic test_quaternion_cases();
		write_reg(REG_KEY_COUNT, 2);
		write_reg(REG_LANE_COUNT, 4);
		send_item(load_item(0, 0, 0, 0, 0, 0));
		send_item(load_item(1, 65536, 0, 0, 0, 0));
		send_item(sample_item(32768));
		send_item(load_item(0, 0, 65536, 0, 0, 0));
		send_item(load_item(1, 65536, -65536, 0, 0, 0));
		send_item(sample_item(32768));
		send_item(sample_item(16384));
		send_item(load_item(1, 0, 0, 65536, 0, 0));
		send_item(sample_item(0));
		send_item(load_item(1, -65536, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		send_item(sample_item(0));
		drain();
		// restore an ascending channel for what follows
		test_full_load();
	endtask

	task automatic test_random_phases();
		int  t0, stp, nk, qlo, qhi;
		longint tt;
		in_item_t it;
		for (int ph = 0; ph < 20; ph++) begin
			idling_on = ph < 17;
			drain();
			if (ph == 0) write_reg(REG_KEY_COUNT, 127);
			else if (ph == 1) write_reg(REG_KEY_COUNT, 0);
			else if ($urandom_range(0, 2) == 0) write_reg(REG_KEY_COUNT, $urandom_range(0, 127));
			else write_reg(REG_KEY_COUNT, $urandom_range(1, 8));
			write_reg(REG_LANE_COUNT, ph < 8 ? ph : $urandom_range(0, 7));
			nk = key_count_reg > MAX_KEYS ? MAX_KEYS : key_count_reg;
			stp = $urandom_range(1, 1 << $urandom_range(2, 24));
			t0 = -$urandom_range(0, 1 << 30);
			for (int j = 0; j < 18; j++) begin
				if ($urandom_range(0, 9) < 3) begin
					it = load_item($urandom_range(0, 63), 0, $urandom, $urandom, $urandom,
						$urandom);
					tt = longint'(t0) + longint'(it.key_index) * stp
						+ $urandom_range(0, stp - 1);
					if ($urandom_range(0, 9) != 0) it.key_time = tt[31:0];
					if (lane_count_reg >= 4 && $urandom_range(0, 7) == 0) begin
						it.value_0 = 0; it.value_1 = 0; it.value_2 = 0; it.value_3 = 0;
					end
				end else begin
					qlo = t0 - stp;
					qhi = t0 + (nk + 1) * stp;
					it = sample_item($urandom_range(0, 9) == 0 ? $urandom
						: $urandom_range(0, qhi - qlo) + qlo);
				end
				send_item(it);
				maybe_pause();
			end
		end
	endtask

	initial begin
		errors = 0;
		idling_on = 1'b1;
		key_count_reg = 0;
		lane_count_reg = 3;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_COUNT;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_channel();
		drain();
		test_full_load();
		test_interpolation();
		test_quaternion_cases();
		test_random_phases();
		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
